>>> src/sasm_pkg.sv
// sasm_pkg: shared types, constants and state codes of the six-axis median filter.
// No dependencies.
`timescale 1ns / 1ps
package sasm_pkg;
  localparam int MAX_WINDOW = 16;
  localparam int CHANNELS = 6;
  localparam int SAMPLE_BITS = 32;
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W = 5;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = $clog2(CHANNELS * MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  localparam logic [0:0] REG_USE_MEDIAN = 1'd0;
  localparam logic [0:0] REG_WINDOW_LEN = 1'd1;
  localparam logic REQ_SAMPLE = 1'b0;

  typedef struct packed {
    logic        req_type;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] filt_force_x;
    logic signed [31:0] filt_force_y;
    logic signed [31:0] filt_force_z;
    logic signed [31:0] filt_torque_x;
    logic signed [31:0] filt_torque_y;
    logic signed [31:0] filt_torque_z;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WRITE, ST_PIVOT, ST_SCAN, ST_NEXT, ST_DONE
  } state_t;

  function automatic logic signed [31:0] sext(input logic [31:0] v);
    logic [SAMPLE_BITS-1:0] low;
    low = v[SAMPLE_BITS-1:0];
    return 32'($signed(low));
  endfunction
endpackage

>>> src/six_axis_sliding_median.sv
// six_axis_sliding_median: per-channel ring of recent samples with rank-search median.
// Depends on sasm_pkg and sasm_ram.
// Reset: synchronous active low; then a clearing pass zeroes every word of the store
//   (input not ready meanwhile, config writes taken).
// Sample word: one RAM write per channel, then the next word can be taken; no result.
// Tick word with median: per channel, each of the n window entries is taken as pivot in
//   turn (states PIVOT, SCAN over the window, NEXT); raw mode goes straight to DONE.
//   The single RAM read port sets this pace. Result waits in an output register.
`timescale 1ns / 1ps
module six_axis_sliding_median (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sasm_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sasm_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [4:0]         cfg_data
);
  localparam int AW = sasm_pkg::ADDR_W;
  localparam int DEPTH = sasm_pkg::CHANNELS * sasm_pkg::MAX_WINDOW;
  localparam int SW = sasm_pkg::SLOT_W;
  localparam int CW = sasm_pkg::CNT_W;

  sasm_pkg::state_t state_r, state_nxt;
  logic use_median_r;
  logic [sasm_pkg::LEN_W-1:0] window_len_r;
  logic [SW-1:0] wslot_r;
  logic [AW-1:0] clr_r;
  logic [sasm_pkg::CH_W-1:0] ch_r;
  logic signed [31:0] samp_r [sasm_pkg::CHANNELS];
  logic signed [31:0] newest_r [sasm_pkg::CHANNELS];
  logic [CW-1:0] piv_r;   // pivot index within window
  logic [CW-1:0] rd_r;    // scan read index (issue side)
  logic          rv_r;    // read data valid for scan
  logic [CW-1:0] lt_r, le_r;
  logic signed [31:0] pv_r;
  logic          lo_f_r;
  logic signed [31:0] lo_r, hi_r;
  logic signed [31:0] res_r [6];
  logic out_valid_r;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] k_lo, k_hi;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  logic in_acc;

  // effective window: clamp 0 to 1 and saturate at the ring depth
  always_comb begin
    if (window_len_r == '0) n_eff = CW'(1);
    else if (32'(window_len_r) > sasm_pkg::MAX_WINDOW) n_eff = CW'(sasm_pkg::MAX_WINDOW);
    else n_eff = CW'(window_len_r);
    k_hi = n_eff >> 1;
    k_lo = n_eff[0] ? k_hi : k_hi - CW'(1);
  end

  // address of window entry i of channel ch: i steps back from the newest slot
  function automatic logic [AW-1:0] waddr_of(input logic [sasm_pkg::CH_W-1:0] c,
                                              input logic [CW-1:0] i,
                                              input logic [SW-1:0] ws);
    logic [SW-1:0] s;
    s = SW'(32'(ws) + sasm_pkg::MAX_WINDOW - 1 - 32'(i));
    return AW'(32'(c) * sasm_pkg::MAX_WINDOW + 32'(s));
  endfunction

  // rank value including the pivot finished this cycle
  function automatic logic signed [31:0] lo_r_sel(input logic [CW-1:0] k);
    logic hit;
    hit = (k >= lt_r) && (k < le_r);
    if (hit) return pv_r;
    else if (k == k_lo && lo_f_r) return lo_r;
    else return hi_r;
  endfunction

  sasm_ram #(.DEPTH(DEPTH), .AW(AW), .DW(32)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ready  = (state_r == sasm_pkg::ST_IDLE) && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = '{res_r[0], res_r[1], res_r[2], res_r[3], res_r[4], res_r[5]};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sasm_pkg::ST_CLEAR: if (32'(clr_r) == DEPTH - 1) state_nxt = sasm_pkg::ST_IDLE;
      sasm_pkg::ST_IDLE: if (in_acc) begin
        if (in_data.req_type == sasm_pkg::REQ_SAMPLE) state_nxt = sasm_pkg::ST_WRITE;
        else if (use_median_r) state_nxt = sasm_pkg::ST_PIVOT;
        else state_nxt = sasm_pkg::ST_DONE;
      end
      sasm_pkg::ST_WRITE:
        if (32'(ch_r) == sasm_pkg::CHANNELS - 1) state_nxt = sasm_pkg::ST_IDLE;
      sasm_pkg::ST_PIVOT: state_nxt = sasm_pkg::ST_SCAN;
      sasm_pkg::ST_SCAN: if (rv_r && rd_r == n_eff) state_nxt = sasm_pkg::ST_NEXT;
      sasm_pkg::ST_NEXT: begin
        if (piv_r == n_eff - CW'(1)) begin
          if (32'(ch_r) == sasm_pkg::CHANNELS - 1) state_nxt = sasm_pkg::ST_DONE;
          else state_nxt = sasm_pkg::ST_PIVOT;
        end else state_nxt = sasm_pkg::ST_PIVOT;
      end
      sasm_pkg::ST_DONE: state_nxt = sasm_pkg::ST_IDLE;
      default: state_nxt = sasm_pkg::ST_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    we = 1'b0;
    waddr = clr_r;
    wdata = '0;
    raddr = waddr_of(ch_r, piv_r, wslot_r);
    unique case (state_r)
      sasm_pkg::ST_CLEAR: we = 1'b1;
      sasm_pkg::ST_WRITE: begin
        we = 1'b1;
        waddr = AW'(32'(ch_r) * sasm_pkg::MAX_WINDOW + 32'(wslot_r));
        wdata = samp_r[ch_r];
      end
      sasm_pkg::ST_SCAN: raddr = waddr_of(ch_r, rd_r, wslot_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sasm_pkg::ST_CLEAR;
      use_median_r <= 1'b1;
      window_len_r <= 5'd16;
      wslot_r <= '0;
      clr_r <= '0;
      ch_r <= '0;
      out_valid_r <= 1'b0;
      piv_r <= '0;
      rd_r <= '0;
      rv_r <= 1'b0;
      for (int c = 0; c < sasm_pkg::CHANNELS; c++) newest_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          sasm_pkg::REG_USE_MEDIAN: use_median_r <= cfg_data[0];
          sasm_pkg::REG_WINDOW_LEN: window_len_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        sasm_pkg::ST_CLEAR: clr_r <= clr_r + AW'(1);
        sasm_pkg::ST_IDLE: if (in_acc) begin
          ch_r <= '0;
          piv_r <= '0;
          if (in_data.req_type == sasm_pkg::REQ_SAMPLE) begin
            samp_r[0] <= sasm_pkg::sext(in_data.force_x);
            samp_r[1] <= sasm_pkg::sext(in_data.force_y);
            samp_r[2] <= sasm_pkg::sext(in_data.force_z);
            samp_r[3] <= sasm_pkg::sext(in_data.torque_x);
            samp_r[4] <= sasm_pkg::sext(in_data.torque_y);
            samp_r[5] <= sasm_pkg::sext(in_data.torque_z);
          end
        end
        sasm_pkg::ST_WRITE: begin
          newest_r[ch_r] <= samp_r[ch_r];
          ch_r <= ch_r + sasm_pkg::CH_W'(1);
          if (32'(ch_r) == sasm_pkg::CHANNELS - 1) wslot_r <= wslot_r + SW'(1);
        end
        sasm_pkg::ST_PIVOT: begin
          // pivot read issued; first scan read next cycle
          rd_r <= '0;
          rv_r <= 1'b0;
          lt_r <= '0;
          le_r <= '0;
          if (piv_r == '0) lo_f_r <= 1'b0;
        end
        sasm_pkg::ST_SCAN: begin
          if (!rv_r) pv_r <= $signed(rdata);
          else begin
            if ($signed(rdata) < pv_r) lt_r <= lt_r + CW'(1);
            if ($signed(rdata) <= pv_r) le_r <= le_r + CW'(1);
          end
          rv_r <= 1'b1;
          rd_r <= rd_r + CW'(1);
        end
        sasm_pkg::ST_NEXT: begin
          // pivot holds ranks lt..le-1 of the sorted window
          if (k_lo >= lt_r && k_lo < le_r) begin lo_f_r <= 1'b1; lo_r <= pv_r; end
          if (k_hi >= lt_r && k_hi < le_r) hi_r <= pv_r;
          if (piv_r == n_eff - CW'(1)) begin
            piv_r <= '0;
            res_r[ch_r] <= 32'((33'(lo_r_sel(k_lo)) + 33'(lo_r_sel(k_hi))) >>> 1);
            ch_r <= ch_r + sasm_pkg::CH_W'(1);
          end else piv_r <= piv_r + CW'(1);
        end
        sasm_pkg::ST_DONE: begin
          out_valid_r <= 1'b1;
          if (!use_median_r)
            for (int c = 0; c < sasm_pkg::CHANNELS; c++) res_r[c] <= newest_r[c];
          for (int c = sasm_pkg::CHANNELS; c < 6; c++) res_r[c] <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> src/sasm_ram.sv
// sasm_ram: single-port-write, one-read synchronous RAM holding the sample windows.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module sasm_ram #(
  parameter int DEPTH = 96,
  parameter int AW = 7,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> src/sasm_checker.sv
// sasm_checker: port-level assertions for six_axis_sliding_median, bound to the top.
// Depends on sasm_pkg.
`timescale 1ns / 1ps
module sasm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input sasm_pkg::out_word_t out_data
);
  // a result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");
  // one item at a time: no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready with result pending");
  // an accepted word closes the input side next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");
  // reset clears the result side
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind six_axis_sliding_median sasm_checker u_sasm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

>>> sim/sasm_median_checker.sv
// sasm_median_checker: watches the channels of six_axis_sliding_median, predicts each result
// word and compares it field by field. Depends on sasm_pkg.
`timescale 1ns / 1ps
module sasm_median_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sasm_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sasm_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [4:0]          cfg_data,
  output int                  fail_count,
  output int                  pending
);
  typedef logic signed [31:0] smp_t;

  smp_t        ring [sasm_pkg::CHANNELS][sasm_pkg::MAX_WINDOW];
  smp_t        latest [sasm_pkg::CHANNELS];
  logic [sasm_pkg::SLOT_W-1:0] slot;
  logic        median_on;
  logic [4:0]  win_len;
  sasm_pkg::out_word_t filtered_q[$];

  string chan_name [6] = '{"filt_force_x", "filt_force_y", "filt_force_z",
                           "filt_torque_x", "filt_torque_y", "filt_torque_z"};

  // Keep the low SAMPLE_BITS bits and sign-extend them.
  function automatic smp_t trim_sample(logic [31:0] v);
    longint t;
    t = longint'(v);
    t = (t <<< (64 - sasm_pkg::SAMPLE_BITS)) >>> (64 - sasm_pkg::SAMPLE_BITS);
    return smp_t'(t);
  endfunction

  function automatic smp_t window_mid(int ch, int n);
    smp_t   vals [sasm_pkg::MAX_WINDOW];
    smp_t   v;
    int     j;
    longint s;
    for (int i = 0; i < n; i++)
      vals[i] = ring[ch][(int'(slot) + sasm_pkg::MAX_WINDOW - 1 - i) % sasm_pkg::MAX_WINDOW];
    for (int i = 1; i < n; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    if (n % 2 == 0) begin
      s = longint'(vals[n/2 - 1]) + longint'(vals[n/2]);
      return smp_t'(s >>> 1);  // floor division
    end
    return vals[n/2];
  endfunction

  function automatic sasm_pkg::out_word_t predict_tick();
    smp_t      r [6];
    int        n;
    sasm_pkg::out_word_t w;
    n = (win_len < 1) ? 1 :
        (win_len > sasm_pkg::MAX_WINDOW) ? sasm_pkg::MAX_WINDOW : int'(win_len);
    for (int c = 0; c < 6; c++)
      r[c] = (c >= sasm_pkg::CHANNELS) ? '0 : median_on ? window_mid(c, n) : latest[c];
    w = '{r[0], r[1], r[2], r[3], r[4], r[5]};
    return w;
  endfunction

  always @(posedge clk) begin
    smp_t      inv [6];
    smp_t      got [6];
    smp_t      want [6];
    sasm_pkg::out_word_t exp_w;
    if (!rst_n) begin
      for (int c = 0; c < sasm_pkg::CHANNELS; c++) begin
        latest[c] = '0;
        for (int k = 0; k < sasm_pkg::MAX_WINDOW; k++) ring[c][k] = '0;
      end
      slot = '0;
      median_on = 1'b1;
      win_len = 5'd16;
      filtered_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sasm_pkg::REG_USE_MEDIAN: median_on = cfg_data[0];
          sasm_pkg::REG_WINDOW_LEN: win_len = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          exp_w = filtered_q.pop_front();
          got  = '{out_data.filt_force_x, out_data.filt_force_y, out_data.filt_force_z,
                   out_data.filt_torque_x, out_data.filt_torque_y, out_data.filt_torque_z};
          want = '{exp_w.filt_force_x, exp_w.filt_force_y, exp_w.filt_force_z,
                   exp_w.filt_torque_x, exp_w.filt_torque_y, exp_w.filt_torque_z};
          for (int c = 0; c < 6; c++)
            if (got[c] !== want[c]) begin
              $error("%s: expected %0d, got %0d", chan_name[c], want[c], got[c]);
              fail_count++;
            end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.req_type == sasm_pkg::REQ_SAMPLE) begin
          inv = '{in_data.force_x, in_data.force_y, in_data.force_z,
                  in_data.torque_x, in_data.torque_y, in_data.torque_z};
          for (int c = 0; c < sasm_pkg::CHANNELS; c++) begin
            latest[c] = trim_sample(inv[c]);
            ring[c][slot] = latest[c];
          end
          slot = slot + 1'b1;
        end else begin
          filtered_q.push_back(predict_tick());
        end
      end
    end
    pending = filtered_q.size();
  end
endmodule

>>> sim/six_axis_sliding_median_test.sv
// six_axis_sliding_median_test: stimulus and verdict for six_axis_sliding_median.
// Depends on sasm_pkg, the block and sasm_median_checker.
`timescale 1ns / 1ps
module six_axis_sliding_median_test;
  localparam logic REQ_TICK = ~sasm_pkg::REQ_SAMPLE;
  localparam int   IDLE_LIMIT = 20000;   // must outlast a 16-deep median tick
  localparam int   SETTLE_CYCLES = 40;   // a sample word may still be writing

  localparam logic       MED_TAB [12] = '{1, 1, 0, 1, 1, 1, 1, 1, 0, 1, 1, 1};
  localparam logic [4:0] LEN_TAB [12] = '{1, 3, 16, 2, 7, 16, 31, 0, 5, 4, 12, 8};
  localparam int         TICK_TAB [12] = '{25, 25, 30, 25, 20, 8, 8, 25, 30, 25, 12, 15};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sasm_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sasm_pkg::out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [0:0] cfg_index = sasm_pkg::REG_USE_MEDIAN;
  logic [4:0] cfg_data = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit hold_req = 1'b0;  // asks the receiver for one long stall

  always #10 clk = ~clk;

  six_axis_sliding_median DUT (.*);

  sasm_median_checker checker_i (.*);

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: mostly ready, short stalls, an occasional long one, and one very
  // long hold when asked so the output register fills and the input backs up.
  initial begin
    int r;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (700) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 92) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(20, 150)) @(posedge clk);
        end
      end
    end
  end

  // Gap before a word: zero often, short mostly, long now and then.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Called on a rising edge; returns on the edge that accepts the word.
  task automatic send_word(sasm_pkg::in_word_t w, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic sasm_pkg::in_word_t make_word(logic kind, logic [31:0] v0,
                                                   logic [31:0] v1, logic [31:0] v2,
                                                   logic [31:0] v3, logic [31:0] v4,
                                                   logic [31:0] v5);
    sasm_pkg::in_word_t w;
    w = '{kind, v0, v1, v2, v3, v4, v5};
    return w;
  endfunction

  task automatic send_all(logic kind, logic [31:0] v);
    send_word(make_word(kind, v, v, v, v, v, v), pick_gap());
  endtask

  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 7) return 32'($signed($urandom_range(0, 20)) - 10);  // ties, signs near zero
    if (r < 8) return 32'h7FFF_FFFF;
    if (r < 9) return 32'h8000_0000;
    return $urandom_range(0, 3);
  endfunction

  // Waits for every expected result, then for a sample write still in flight.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(logic med, logic [4:0] len);
    drain();
    write_reg(sasm_pkg::REG_USE_MEDIAN, {4'd0, med});
    write_reg(sasm_pkg::REG_WINDOW_LEN, len);
  endtask

  // Random phase: mostly samples, some ticks; sample fields random on ticks too.
  task automatic run_phase(int words, int tick_pct);
    logic kind;
    for (int i = 0; i < words; i++) begin
      kind = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : sasm_pkg::REQ_SAMPLE;
      send_word(make_word(kind, rand_value(), rand_value(), rand_value(),
                          rand_value(), rand_value(), rand_value()), pick_gap());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Tick before any sample: an unfilled window reads zeros.
    send_all(REQ_TICK, 32'h1234_5678);
    send_all(sasm_pkg::REQ_SAMPLE, 32'h7FFF_FFFF);
    send_all(sasm_pkg::REQ_SAMPLE, 32'h8000_0000);
    send_all(sasm_pkg::REQ_SAMPLE, 32'h0000_0000);
    send_all(sasm_pkg::REQ_SAMPLE, 32'hFFFF_FFFF);
    send_all(sasm_pkg::REQ_SAMPLE, 32'h5555_5555);
    send_all(sasm_pkg::REQ_SAMPLE, 32'hAAAA_AAAA);
    send_all(REQ_TICK, 32'h0);          // partly filled, full length window
    // Raw mode returns the newest sample.
    set_mode(1'b0, 5'd16);
    send_all(REQ_TICK, 32'h0);
    // Even window: -1 and 0 average rounds down to -1.
    set_mode(1'b1, 5'd2);
    send_all(sasm_pkg::REQ_SAMPLE, 32'hFFFF_FFFF);
    send_all(sasm_pkg::REQ_SAMPLE, 32'h0000_0000);
    send_all(REQ_TICK, 32'h0);
    // Sums that overflow 32 bits in both directions.
    send_all(sasm_pkg::REQ_SAMPLE, 32'h8000_0000);
    send_all(sasm_pkg::REQ_SAMPLE, 32'h8000_0000);
    send_all(REQ_TICK, 32'h0);
    send_all(sasm_pkg::REQ_SAMPLE, 32'h7FFF_FFFF);
    send_all(sasm_pkg::REQ_SAMPLE, 32'h7FFF_FFFF);
    send_all(REQ_TICK, 32'h0);
    // Length zero acts as one; above the ring depth saturates.
    set_mode(1'b1, 5'd0);
    send_all(REQ_TICK, 32'h0);
    set_mode(1'b1, 5'd31);
    send_all(REQ_TICK, 32'h0);

    // Random phases over several settings.
    for (int p = 0; p < 12; p++) begin
      set_mode(MED_TAB[p], LEN_TAB[p]);
      if (p == 2) hold_req = 1'b1;  // raw ticks are fast: the output backs up
      run_phase(125, TICK_TAB[p]);
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
